// ===== design/pidaw_pkg.sv =====
// Shared constants, codes and helpers of the PID regulator with adaptive gain.
package pidaw_pkg;

  localparam int FRAC_BITS = 16;

  // Sequencer step counts of the shared multiply and divide unit
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 96;
  localparam logic [6:0] MUL_LAST = 7'(MUL_STEPS - 1);
  localparam logic [6:0] DIV_LAST = 7'(DIV_STEPS - 1);

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint GAIN_LO_RAW = (3 * ONE) / 2;
  localparam longint GAIN_HI_RAW = 5 * ONE;
  localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;
  localparam logic [23:0] GAIN_LO =
    (GAIN_LO_RAW > longint'(GAIN_MAX)) ? GAIN_MAX : 24'(GAIN_LO_RAW);
  localparam logic [23:0] GAIN_HI =
    (GAIN_HI_RAW > longint'(GAIN_MAX)) ? GAIN_MAX : 24'(GAIN_HI_RAW);

  localparam logic signed [63:0] OUT_MAX_RST = 64'(350 * ONE);
  localparam logic signed [63:0] OUT_MIN_RST = 64'(-350 * ONE);

  localparam logic [32:0] BIG_ERR   = 33'(7 * ONE);
  localparam logic [32:0] SMALL_ERR = 33'(ONE);

  localparam logic [31:0] USEC_PER_SEC  = 32'd1000000;
  localparam logic [31:0] GROW_DIVISOR  = 32'd200;
  localparam logic [31:0] DECAY_DIVISOR = 32'd100;
  localparam logic [60:0] MAG_CAP = 61'h1000000000000000;

  // Command codes
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_ADAPT  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_KP      = 3'd0;
  localparam logic [2:0] REG_KI      = 3'd1;
  localparam logic [2:0] REG_KD      = 3'd2;
  localparam logic [2:0] REG_OUT_MIN = 3'd3;
  localparam logic [2:0] REG_OUT_MAX = 3'd4;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/pid_antiwindup_adaptive_gain.sv =====
// PID regulator top level: sequencer around one shared shift-add multiplier and divider.
//
// Input channel (in_valid/in_ready) takes one word: command, setpoint,
// measured, elapsed_us. Output channel (out_valid/out_ready) returns one
// word per input: drive and gain_now after the command.
// Configuration: cfg_we with cfg_index and cfg_data writes a register;
// write it only while the block is idle.
// Timing: in_ready is high only in the idle state. An update runs three
// 32-step multiplies, two more 32-step multiplies and two 96-step restoring
// divides on the shared unit. Adapt takes one 96-step divide; clear, the
// unused command and an adapt with unchanged error skip the shared unit.
// The multiply and divide steps handle one bit per cycle.
// Results sit in an output register; the next word is accepted while a
// result waits, and a stalled receiver holds the block at its final step
// until the result is taken.
// Reset (rst, synchronous) clears the state machine, gains, integral, history
// and held drive, loads the drive bounds to +-350.0 and drops any pending result.
module pid_antiwindup_adaptive_gain
  import pidaw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] setpoint,
  input  logic signed [31:0] measured,
  input  logic [31:0]        elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive,
  output logic [23:0]        gain_now,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_MUL_EK, S_MUL_AEL, S_DIV_I, S_INT_ACC, S_MUL_DK, S_MUL_B,
    S_DIV_D, S_D_SAVE, S_MUL_P, S_SUM, S_CLAMP, S_ADIV, S_AFIN, S_DONE
  } state_t;

  state_t state;

  logic [1:0]         cmd_r;
  logic signed [31:0] sp_r, ms_r;
  logic [31:0]        el_r;

  logic [23:0]        ki, kd, kp_w;
  logic signed [63:0] omin, omax, held, sum_r;
  logic signed [31:0] integ, prev_ms, prev_ae, ea_r;
  logic               a_big, a_small;

  logic [95:0] acc;
  logic [63:0] mcand;
  logic [31:0] mplr, rem, divisor;
  logic [6:0]  cnt;

  logic signed [32:0] err, dm;
  logic [32:0]        err_mag, dm_mag;
  logic [31:0]        el_fix;
  logic [64:0]        msum;
  logic [95:0]        mul_next;
  logic [32:0]        dtrial, ddiff;
  logic               dfit;
  logic [60:0]        qcap, tmag;
  logic [63:0]        tword, pmag;
  logic signed [63:0] iterm, dterm, pterm, integ64;
  logic               over, under;
  logic signed [31:0] integ_hi, integ_lo, e_sat;
  logic [31:0]        ea;
  logic signed [33:0] delta, kp_sum;
  logic [23:0]        kp_clamped;
  logic               last_mul, last_div;

  assign in_ready = (state == S_IDLE);
  assign last_mul = (cnt == MUL_LAST);
  assign last_div = (cnt == DIV_LAST);

  // Operand shaping
  always_comb begin
    err     = {sp_r[31], sp_r} - {ms_r[31], ms_r};
    dm      = {ms_r[31], ms_r} - {prev_ms[31], prev_ms};
    err_mag = err[32] ? 33'(33'd0 - err) : err;
    dm_mag  = dm[32] ? 33'(33'd0 - dm) : dm;
    el_fix  = (el_r == 32'd0) ? 32'd1 : el_r;
    integ64 = {{32{integ[31]}}, integ};
  end

  // Shared unit: one shift-add multiply step and one restoring divide step
  always_comb begin
    msum     = {1'b0, acc[95:32]} + (mplr[0] ? {1'b0, mcand} : 65'd0);
    mul_next = {msum, acc[31:1]};
    dtrial   = {rem, acc[95]};
    dfit     = (dtrial >= {1'b0, divisor});
    ddiff    = dtrial - {1'b0, divisor};
  end

  // Term forming from the unit's quotient or product
  always_comb begin
    qcap  = (|acc[95:60]) ? MAG_CAP : acc[60:0];
    tmag  = qcap >> FRAC_BITS;
    tword = {3'b000, tmag};
    iterm = err[32] ? $signed(64'd0 - tword) : $signed(tword);
    dterm = (!dm[32] && (dm != 33'sd0)) ? $signed(64'd0 - tword) : $signed(tword);
    pmag  = acc[63:0] >> FRAC_BITS;
    pterm = err[32] ? $signed(64'd0 - pmag) : $signed(pmag);
  end

  // Clamp with back-calculation into the integral
  always_comb begin
    over     = (sum_r > omax);
    under    = (sum_r < omin);
    integ_hi = sat32(integ64 - (sum_r - omax));
    integ_lo = sat32(integ64 + (omin - sum_r));
  end

  // Gain adaptation
  always_comb begin
    e_sat = sat32(64'(err));
    ea    = e_sat[31] ? (32'd0 - e_sat) : e_sat;
    if (a_big) begin
      delta = (ea_r > prev_ae) ? $signed({2'b00, acc[31:0]})
                               : $signed(34'd0 - {2'b00, acc[31:0]});
    end else if (a_small) begin
      delta = $signed(34'd0 - {2'b00, acc[31:0]});
    end else begin
      delta = 34'sd0;
    end
    kp_sum = $signed({10'd0, kp_w}) + delta;
    if (kp_sum < $signed({10'd0, GAIN_LO})) kp_clamped = GAIN_LO;
    else if (kp_sum > $signed({10'd0, GAIN_HI})) kp_clamped = GAIN_HI;
    else kp_clamped = kp_sum[23:0];
  end

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ki        <= 24'd0;
      kd        <= 24'd0;
      kp_w      <= 24'd0;
      omin      <= OUT_MIN_RST;
      omax      <= OUT_MAX_RST;
      integ     <= 32'sd0;
      prev_ms   <= 32'sd0;
      prev_ae   <= 32'sd0;
      held      <= 64'sd0;
      cnt       <= 7'd0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;

      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:      kp_w <= cfg_data[23:0];
          REG_KI:      ki   <= cfg_data[23:0];
          REG_KD:      kd   <= cfg_data[23:0];
          REG_OUT_MIN: omin <= {{32{cfg_data[31]}}, cfg_data};
          REG_OUT_MAX: omax <= {{32{cfg_data[31]}}, cfg_data};
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= command;
            sp_r  <= setpoint;
            ms_r  <= measured;
            el_r  <= elapsed_us;
            state <= S_START;
          end
        end
        S_START: begin
          cnt <= 7'd0;
          case (cmd_r)
            CMD_UPDATE: begin
              acc   <= 96'd0;
              mcand <= {31'd0, err_mag};
              mplr  <= {8'd0, ki};
              state <= S_MUL_EK;
            end
            CMD_ADAPT: begin
              if (e_sat == prev_ae) begin
                state <= S_DONE;
              end else begin
                ea_r    <= e_sat;
                a_big   <= ({1'b0, ea} >= BIG_ERR);
                a_small <= ({1'b0, ea} < SMALL_ERR);
                acc     <= {64'd0, ea};
                rem     <= 32'd0;
                divisor <= ({1'b0, ea} >= BIG_ERR) ? GROW_DIVISOR : DECAY_DIVISOR;
                state   <= S_ADIV;
              end
            end
            CMD_CLEAR: begin
              integ   <= 32'sd0;
              prev_ms <= 32'sd0;
              sum_r   <= held;
              state   <= S_CLAMP;
            end
            default: state <= S_DONE;
          endcase
        end
        S_MUL_EK, S_MUL_AEL, S_MUL_DK, S_MUL_B, S_MUL_P: begin
          acc  <= mul_next;
          mplr <= {1'b0, mplr[31:1]};
          cnt  <= cnt + 7'd1;
          if (last_mul) begin
            cnt <= 7'd0;
            case (state)
              S_MUL_EK: begin
                acc   <= 96'd0;
                mcand <= mul_next[63:0];
                mplr  <= el_fix;
                state <= S_MUL_AEL;
              end
              S_MUL_AEL: begin
                rem     <= 32'd0;
                divisor <= USEC_PER_SEC;
                state   <= S_DIV_I;
              end
              S_MUL_DK: begin
                acc   <= 96'd0;
                mcand <= mul_next[63:0];
                mplr  <= USEC_PER_SEC;
                state <= S_MUL_B;
              end
              S_MUL_B: begin
                rem     <= 32'd0;
                divisor <= el_fix;
                state   <= S_DIV_D;
              end
              default: state <= S_SUM;
            endcase
          end
        end
        S_DIV_I, S_DIV_D, S_ADIV: begin
          acc <= {acc[94:0], dfit};
          rem <= dfit ? ddiff[31:0] : dtrial[31:0];
          cnt <= cnt + 7'd1;
          if (last_div) begin
            cnt <= 7'd0;
            case (state)
              S_DIV_I: state <= S_INT_ACC;
              S_DIV_D: state <= S_D_SAVE;
              default: state <= S_AFIN;
            endcase
          end
        end
        S_INT_ACC: begin
          integ <= sat32(integ64 + iterm);
          acc   <= 96'd0;
          mcand <= {31'd0, dm_mag};
          mplr  <= {8'd0, kd};
          state <= S_MUL_DK;
        end
        S_D_SAVE: begin
          sum_r <= dterm;
          acc   <= 96'd0;
          mcand <= {31'd0, err_mag};
          mplr  <= {8'd0, kp_w};
          state <= S_MUL_P;
        end
        S_SUM: begin
          sum_r <= pterm + integ64 + sum_r;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (over) begin
            integ <= integ_hi;
            held  <= omax;
          end else if (under) begin
            integ <= integ_lo;
            held  <= omin;
          end else begin
            held <= sum_r;
          end
          if (cmd_r == CMD_UPDATE) prev_ms <= ms_r;
          state <= S_DONE;
        end
        S_AFIN: begin
          kp_w    <= kp_clamped;
          prev_ae <= ea_r;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            drive     <= held[31:0];
            gain_now  <= kp_w;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Adapted gain lands inside its bounds
  assert property (@(posedge clk) disable iff (rst)
    (state == S_AFIN) |=> (kp_w >= GAIN_LO) && (kp_w <= GAIN_HI))
    else $error("adapted gain out of bounds");

  // Accepted word leaves the idle state at once
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after accept");

  // Finishing publishes the held drive
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=>
      out_valid && (drive == $past(held[31:0])) && (gain_now == $past(kp_w)))
    else $error("result word not published");

  // Step counter stays within the divide length
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (cnt <= DIV_LAST))
    else $error("step counter overrun");

endmodule
